>>> sv/rmsd_pkg.sv
// rmsd_pkg: shared constants, register indexes and datapath command type
package rmsd_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int MS_BITS       = 47;
	localparam int WINDOW_SHIFT  = 21;
	localparam int ROOT_BITS     = (MS_BITS + 1) / 2;
	localparam int RAD_BITS      = 2 * ROOT_BITS;
	localparam int REM_BITS      = ROOT_BITS + 2;
	localparam int POS_BITS      = $clog2(ROOT_BITS + 1);
	localparam int STEP_BITS     = $clog2(ROOT_BITS);
	localparam int DB_BITS       = 9;
	localparam int FRAC_BITS     = 8;
	localparam int DB_PER_BIT    = 6;

	localparam logic [MS_BITS-1:0] RESEED_VALUE = MS_BITS'(64'd17592186044416);
	localparam logic signed [DB_BITS-1:0] SILENCE_DB = -9'sd144;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 9;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_VALID    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_FLOOR   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_CEILING = 2'd2;

	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_RESEED     = 1'b1;

	typedef struct packed {
		logic load;
		logic square;
		logic diff;
		logic update;
		logic root_step;
		logic out_load;
	} dp_cmd_t;

endpackage

>>> sv/rmsd_if.sv
// rmsd_if: request channel and level result channel interfaces
interface rmsd_item_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    command;
	logic signed [rmsd_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink (input valid, input command, input sample, output ready);
endinterface

interface rmsd_level_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [rmsd_pkg::DB_BITS-1:0]   rms_dbfs;
	logic signed [rmsd_pkg::DB_BITS-1:0]   clamp_dbfs;
	logic        [rmsd_pkg::ROOT_BITS-1:0] rms_magnitude;

	modport source (output valid, output rms_dbfs, output clamp_dbfs, output rms_magnitude,
		input ready);
	modport sink (input valid, input rms_dbfs, input clamp_dbfs, input rms_magnitude,
		output ready);
endinterface

>>> sv/rmsd_dp.sv
// rmsd_dp: integrator, bit-serial square root, dBFS conversion and config registers
module rmsd_dp (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  rmsd_pkg::dp_cmd_t                           cmd,
	input  logic                                        item_command,
	input  logic signed [rmsd_pkg::SAMPLE_BITS-1:0]     item_sample,
	input  logic                                        cfg_wr_en,
	input  logic        [rmsd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic        [rmsd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic signed [rmsd_pkg::DB_BITS-1:0]         rms_dbfs,
	output logic signed [rmsd_pkg::DB_BITS-1:0]         clamp_dbfs,
	output logic        [rmsd_pkg::ROOT_BITS-1:0]       rms_magnitude
);

	localparam int SB = rmsd_pkg::SAMPLE_BITS;
	localparam int MB = rmsd_pkg::MS_BITS;
	localparam int RB = rmsd_pkg::ROOT_BITS;
	localparam int DW = rmsd_pkg::DB_BITS + 1;

	logic                               rate_valid_q;
	logic signed [rmsd_pkg::DB_BITS-1:0] floor_q;
	logic signed [rmsd_pkg::DB_BITS-1:0] ceiling_q;

	logic                               command_q;
	logic        [SB-1:0]               sample_q;
	logic        [MB-1:0]               sq_q;
	logic                               gt_q;
	logic        [MB-1:0]               diff_q;
	logic        [MB-1:0]               ms_q;
	logic        [rmsd_pkg::RAD_BITS-1:0] rad_q;
	logic        [rmsd_pkg::REM_BITS-1:0] rem_q;
	logic        [RB-1:0]               root_q;
	logic        [rmsd_pkg::POS_BITS-1:0] pos_q;
	logic        [rmsd_pkg::FRAC_BITS-1:0] frac_q;
	logic        [rmsd_pkg::FRAC_BITS-1:0] mask_q;

	logic signed [rmsd_pkg::DB_BITS-1:0] rms_dbfs_q;
	logic signed [rmsd_pkg::DB_BITS-1:0] clamp_dbfs_q;
	logic        [RB-1:0]               rms_magnitude_q;

	logic [SB-1:0]                      mag;
	logic [2*SB-1:0]                    prod;
	logic                               gt;
	logic [MB-1:0]                      diff;
	logic [MB-1:0]                      step;
	logic [MB-1:0]                      ms_next;
	logic [rmsd_pkg::REM_BITS+1:0]      cur;
	logic [rmsd_pkg::REM_BITS+1:0]      trial;
	logic                               take;
	logic [rmsd_pkg::REM_BITS+1:0]      rem_sub;
	logic [RB-1:0]                      root_new;
	logic signed [DW-1:0]               pos_s;
	logic signed [DW-1:0]               db_base;
	logic [rmsd_pkg::FRAC_BITS+2:0]     frac6;
	logic signed [DW-1:0]               db_sum;
	logic signed [rmsd_pkg::DB_BITS-1:0] db;
	logic signed [rmsd_pkg::DB_BITS-1:0] t_floor;
	logic signed [rmsd_pkg::DB_BITS-1:0] track;

	// magnitude and square
	assign mag  = sample_q[SB-1] ? (~sample_q + SB'(1)) : sample_q;
	assign prod = {{SB{1'b0}}, mag} * {{SB{1'b0}}, mag};

	// integrator update
	assign gt      = sq_q > ms_q;
	assign diff    = gt ? (sq_q - ms_q) : (ms_q - sq_q);
	assign step    = diff_q >> rmsd_pkg::WINDOW_SHIFT;

	always_comb begin
		if (command_q == rmsd_pkg::CMD_RESEED) begin
			ms_next = rmsd_pkg::RESEED_VALUE;
		end else if (rate_valid_q) begin
			ms_next = gt_q ? (ms_q + step) : (ms_q - step);
		end else begin
			ms_next = ms_q;
		end
	end

	// one root bit per step
	assign cur      = {rem_q, rad_q[rmsd_pkg::RAD_BITS-1 -: 2]};
	assign trial    = (rmsd_pkg::REM_BITS + 2)'({root_q, 2'b01});
	assign take     = cur >= trial;
	assign rem_sub  = take ? (cur - trial) : cur;
	assign root_new = {root_q[RB-2:0], take};

	// dBFS from msb position and the bits just below it
	assign pos_s   = DW'(signed'({1'b0, pos_q})) - DW'(signed'(SB));
	assign db_base = (pos_s <<< 2) + (pos_s <<< 1);
	assign frac6   = {1'b0, frac_q, 2'b00} + {2'b00, frac_q, 1'b0};
	assign db_sum  = db_base + DW'(frac6[rmsd_pkg::FRAC_BITS+2:rmsd_pkg::FRAC_BITS]);

	always_comb begin
		if (root_q == '0) begin
			db = rmsd_pkg::SILENCE_DB;
		end else if (db_sum > DW'(0)) begin
			db = '0;
		end else begin
			db = db_sum[rmsd_pkg::DB_BITS-1:0];
		end
		t_floor = (db < floor_q) ? floor_q : db;
		track   = (t_floor > ceiling_q) ? ceiling_q : t_floor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_valid_q <= 1'b1;
			floor_q      <= -9'sd60;
			ceiling_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rmsd_pkg::REG_RATE_VALID:    rate_valid_q <= cfg_data[0];
				rmsd_pkg::REG_LEVEL_FLOOR:   floor_q      <= signed'(cfg_data);
				rmsd_pkg::REG_LEVEL_CEILING: ceiling_q    <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
		end else if (cmd.update) begin
			ms_q <= ms_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= item_command;
			sample_q  <= item_sample;
		end
		if (cmd.square) begin
			sq_q <= prod[MB-1:0];
		end
		if (cmd.diff) begin
			gt_q   <= gt;
			diff_q <= diff;
		end
		if (cmd.update) begin
			rad_q  <= rmsd_pkg::RAD_BITS'(ms_next);
			rem_q  <= '0;
			root_q <= '0;
			pos_q  <= '0;
			frac_q <= '0;
			mask_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_sub[rmsd_pkg::REM_BITS-1:0];
			root_q <= root_new;
			if (root_new != '0) begin
				pos_q <= pos_q + 1'b1;
			end
			if (root_q != '0) begin
				if (take) begin
					frac_q <= frac_q | mask_q;
				end
				mask_q <= mask_q >> 1;
			end else if (take) begin
				mask_q <= {1'b1, {(rmsd_pkg::FRAC_BITS-1){1'b0}}};
			end
		end
		if (cmd.out_load) begin
			rms_dbfs_q      <= db;
			clamp_dbfs_q    <= track;
			rms_magnitude_q <= root_q;
		end
	end

	assign rms_dbfs      = rms_dbfs_q;
	assign clamp_dbfs    = clamp_dbfs_q;
	assign rms_magnitude = rms_magnitude_q;

endmodule

>>> sv/rmsd_ctrl.sv
// rmsd_ctrl: sequencer for one request and the result valid flag
module rmsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              level_valid,
	input  logic              level_ready,
	output rmsd_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_DIFF,
		S_UPDATE,
		S_ROOT,
		S_LEVEL
	} state_t;

	state_t                           state_q;
	logic [rmsd_pkg::STEP_BITS-1:0]   step_q;
	logic                             level_valid_q;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && item_valid;
		cmd.square    = (state_q == S_SQUARE);
		cmd.diff      = (state_q == S_DIFF);
		cmd.update    = (state_q == S_UPDATE);
		cmd.root_step = (state_q == S_ROOT);
		cmd.out_load  = (state_q == S_LEVEL) && (!level_valid_q || level_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			level_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				level_valid_q <= 1'b1;
			end else if (level_ready) begin
				level_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: state_q <= S_DIFF;
				S_DIFF:   state_q <= S_UPDATE;
				S_UPDATE: begin
					step_q  <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (step_q == rmsd_pkg::STEP_BITS'(rmsd_pkg::ROOT_BITS - 1)) begin
						state_q <= S_LEVEL;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_LEVEL: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign level_valid = level_valid_q;

endmodule

>>> sv/rms_level_dbfs_meter.sv
// rms_level_dbfs_meter: leaky mean-square integrator with square root and dBFS readout
//
//   channel  dir  handshake        payload
//   item     in   valid/ready      command, sample
//   level    out  valid/ready      rms_dbfs, clamp_dbfs, rms_magnitude
//   cfg      in   cfg_wr_en        cfg_index, cfg_data
//
// a result is loaded after its request is accepted: square, difference, update,
// 24 bit-serial square root steps and one for dBFS; a new request is taken only
// in the idle state after the result is loaded, not while one is in work
// item.ready is high only while idle; a finished result waits in the output
// register while the next request runs, which then holds in its last step
// reset clears the integrator and loads rate_valid 1, floor -60, ceiling 0
module rms_level_dbfs_meter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	rmsd_item_if.sink                             item,
	rmsd_level_if.source                          level,
	input  logic                                  cfg_wr_en,
	input  logic [rmsd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rmsd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	rmsd_pkg::dp_cmd_t cmd;

	rmsd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.level_valid (level.valid),
		.level_ready (level.ready),
		.cmd         (cmd)
	);

	rmsd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_command  (item.command),
		.item_sample   (item.sample),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rms_dbfs      (level.rms_dbfs),
		.clamp_dbfs    (level.clamp_dbfs),
		.rms_magnitude (level.rms_magnitude)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("request accepted while previous one in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!level.valid || level.ready))
		else $error("pending result overwritten");

	a_silence_code: assert property (@(posedge clk) disable iff (!arst_n)
		level.valid |-> ((level.rms_magnitude == '0) == (level.rms_dbfs == rmsd_pkg::SILENCE_DB)))
		else $error("silence code does not match zero magnitude");

	a_level_clip: assert property (@(posedge clk) disable iff (!arst_n)
		level.valid |-> (level.rms_dbfs == '0 || level.rms_dbfs[rmsd_pkg::DB_BITS-1]))
		else $error("level above full scale");

endmodule

>>> tb/level_checker.sv
// level_checker: predicts the meter's level results and compares them with the level channel
module level_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	rmsd_item_if                                item,
	rmsd_level_if                               level,
	input  logic                                cfg_wr_en,
	input  logic [rmsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rmsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                  level_errors,
	output int                                  levels_pending
);

	typedef struct packed {
		logic signed [rmsd_pkg::DB_BITS-1:0] rms_dbfs;
		logic signed [rmsd_pkg::DB_BITS-1:0] clamp_dbfs;
		logic [rmsd_pkg::ROOT_BITS-1:0]      rms_magnitude;
	} level_t;

	logic [rmsd_pkg::MS_BITS-1:0]        mean_sq;
	logic                                rate_on;
	logic signed [rmsd_pkg::DB_BITS-1:0] floor_db;
	logic signed [rmsd_pkg::DB_BITS-1:0] ceil_db;
	level_t                              expected_levels[$];

	// largest r with r*r <= n, one bit at a time from the top
	function automatic logic [rmsd_pkg::ROOT_BITS-1:0] int_sqrt(
		logic [rmsd_pkg::MS_BITS-1:0] n);
		logic [rmsd_pkg::ROOT_BITS-1:0] r;
		logic [rmsd_pkg::ROOT_BITS-1:0] t;
		r = '0;
		for (int b = rmsd_pkg::ROOT_BITS - 1; b >= 0; b--) begin
			t = r | (rmsd_pkg::ROOT_BITS'(1) << b);
			if (64'(t) * 64'(t) <= 64'(n))
				r = t;
		end
		return r;
	endfunction

	function automatic int dbfs_of(logic [rmsd_pkg::ROOT_BITS-1:0] m);
		logic [rmsd_pkg::ROOT_BITS+rmsd_pkg::FRAC_BITS-1:0] wide;
		logic [rmsd_pkg::FRAC_BITS-1:0]                     frac;
		int                                                 msb;
		int                                                 db;
		if (m == '0)
			return int'(rmsd_pkg::SILENCE_DB);
		msb = 0;
		for (int b = 0; b < rmsd_pkg::ROOT_BITS; b++)
			if (m[b])
				msb = b;
		// eight bits just below the leading one, zero padded
		wide = {m, {rmsd_pkg::FRAC_BITS{1'b0}}};
		frac = wide[msb + rmsd_pkg::FRAC_BITS - 1 -: rmsd_pkg::FRAC_BITS];
		db = (msb + 1 - rmsd_pkg::SAMPLE_BITS) * rmsd_pkg::DB_PER_BIT
			+ ((int'(frac) * rmsd_pkg::DB_PER_BIT) >>> rmsd_pkg::FRAC_BITS);
		return (db > 0) ? 0 : db;
	endfunction

	function automatic level_t level_now();
		level_t lv;
		int     db;
		int     trk;
		lv.rms_magnitude = int_sqrt(mean_sq);
		db = dbfs_of(lv.rms_magnitude);
		trk = db;
		// floor first, then ceiling, so the ceiling wins when they cross
		if (trk < int'(floor_db))
			trk = int'(floor_db);
		if (trk > int'(ceil_db))
			trk = int'(ceil_db);
		lv.rms_dbfs = rmsd_pkg::DB_BITS'(db);
		lv.clamp_dbfs = rmsd_pkg::DB_BITS'(trk);
		return lv;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		level_t                           want;
		level_t                           got;
		logic [rmsd_pkg::SAMPLE_BITS-1:0] raw;
		logic [rmsd_pkg::SAMPLE_BITS-1:0] neg;
		logic [63:0]                      mag;
		logic [63:0]                      sq;
		logic [63:0]                      acc;
		if (!arst_n) begin
			mean_sq = '0;
			rate_on = 1'b1;
			floor_db = -9'sd60;
			ceil_db = 9'sd0;
			expected_levels.delete();
			levels_pending = 0;
		end else begin
			if (level.valid && level.ready) begin
				got.rms_dbfs = level.rms_dbfs;
				got.clamp_dbfs = level.clamp_dbfs;
				got.rms_magnitude = level.rms_magnitude;
				if (expected_levels.size() == 0) begin
					level_errors++;
					if (level_errors <= 10)
						$display("unexpected level: dbfs %0d clamp %0d mag %0d",
							got.rms_dbfs, got.clamp_dbfs, got.rms_magnitude);
				end else begin
					want = expected_levels.pop_front();
					if (got.rms_dbfs !== want.rms_dbfs || got.clamp_dbfs !== want.clamp_dbfs ||
						got.rms_magnitude !== want.rms_magnitude) begin
						level_errors++;
						if (level_errors <= 10)
							$display({"level mismatch: expected dbfs %0d clamp %0d mag %0d,",
								" got dbfs %0d clamp %0d mag %0d"},
								want.rms_dbfs, want.clamp_dbfs, want.rms_magnitude,
								got.rms_dbfs, got.clamp_dbfs, got.rms_magnitude);
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.command == rmsd_pkg::CMD_RESEED) begin
					mean_sq = rmsd_pkg::RESEED_VALUE;
				end else if (rate_on) begin
					raw = item.sample;
					neg = ~raw + 1'b1;
					mag = raw[rmsd_pkg::SAMPLE_BITS-1] ? 64'(neg) : 64'(raw);
					sq = mag * mag;
					acc = 64'(mean_sq);
					if (sq > acc)
						acc = acc + ((sq - acc) >> rmsd_pkg::WINDOW_SHIFT);
					else
						acc = acc - ((acc - sq) >> rmsd_pkg::WINDOW_SHIFT);
					mean_sq = acc[rmsd_pkg::MS_BITS-1:0];
				end
				expected_levels.push_back(level_now());
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					rmsd_pkg::REG_RATE_VALID:    rate_on = cfg_data[0];
					rmsd_pkg::REG_LEVEL_FLOOR:   floor_db = cfg_data;
					rmsd_pkg::REG_LEVEL_CEILING: ceil_db = cfg_data;
					default: ;
				endcase
			end
			levels_pending = expected_levels.size();
		end
	end

endmodule

>>> tb/testbench.sv
// testbench: drives the level meter with sample and reseed requests under several pacing schemes
module testbench;

	typedef enum logic [2:0] {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH,
		PACE_PRESSURE
	} pace_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [rmsd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [rmsd_pkg::CFG_DATA_BITS-1:0]  cfg_data;
	pace_t                               pace = PACE_FREE;
	int                                  phase_no = 0;
	int                                  level_errors;
	int                                  levels_pending;

	rmsd_item_if  item_ch();
	rmsd_level_if level_ch();

	rms_level_dbfs_meter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.level     (level_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	level_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.level          (level_ch),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.level_errors   (level_errors),
		.levels_pending (levels_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic sender_gap(pace_t p);
		case (p)
			PACE_SEND_IDLE: return $urandom_range(99) < 87;
			PACE_BOTH:      return $urandom_range(99) < 31;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stall(pace_t p);
		case (p)
			PACE_RECV_STALL: return $urandom_range(99) < 87;
			PACE_BOTH:       return $urandom_range(99) < 31;
			default:         return 1'b0;
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off per pressure phase
	initial begin
		int held_phase;
		int hold_cycles;
		held_phase = -1;
		level_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pace == PACE_PRESSURE && held_phase != phase_no) begin
				held_phase = phase_no;
				level_ch.ready <= 1'b0;
				for (hold_cycles = 0; hold_cycles < 400; hold_cycles++)
					@(posedge clk);
			end
			level_ch.ready <= !receiver_stall(pace);
		end
	end

	task automatic send_item(input logic cmd, input logic [rmsd_pkg::SAMPLE_BITS-1:0] smp);
		while (sender_gap(pace)) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.sample <= smp;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [rmsd_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [rmsd_pkg::CFG_DATA_BITS-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic start_phase(input logic rate,
		input logic [rmsd_pkg::CFG_DATA_BITS-1:0] floor_v,
		input logic [rmsd_pkg::CFG_DATA_BITS-1:0] ceil_v, input pace_t p);
		write_reg(rmsd_pkg::REG_RATE_VALID, rmsd_pkg::CFG_DATA_BITS'(rate));
		write_reg(rmsd_pkg::REG_LEVEL_FLOOR, floor_v);
		write_reg(rmsd_pkg::REG_LEVEL_CEILING, ceil_v);
		cfg_wr_en <= 1'b0;
		pace <= p;
		phase_no <= phase_no + 1;
	endtask

	// all levels back, then a margin for the block's own latency
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (levels_pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [rmsd_pkg::SAMPLE_BITS-1:0] pick_sample();
		logic [rmsd_pkg::SAMPLE_BITS-1:0] s;
		case ($urandom_range(5))
			0, 1: s = rmsd_pkg::SAMPLE_BITS'($urandom);
			2: begin
				case ($urandom_range(4))
					0: s = 24'h7FFFFF;
					1: s = 24'h800000;
					2: s = 24'h000000;
					3: s = 24'h000001;
					default: s = 24'hFFFFFF;
				endcase
			end
			3: begin
				s = rmsd_pkg::SAMPLE_BITS'($urandom_range(1023));
				if ($urandom_range(1))
					s = -s;
			end
			default: begin
				// loud signal drives the integrator toward full scale
				s = {2'b01, 22'($urandom)};
				if ($urandom_range(1))
					s = -s;
			end
		endcase
		return s;
	endfunction

	task automatic run_random(input int count);
		logic cmd;
		repeat (count) begin
			cmd = ($urandom_range(99) < 6) ? rmsd_pkg::CMD_RESEED : rmsd_pkg::CMD_ACCUMULATE;
			send_item(cmd, pick_sample());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= rmsd_pkg::REG_RATE_VALID;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.command <= rmsd_pkg::CMD_ACCUMULATE;
		item_ch.sample <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// silence from reset, extremes, then reseed and decay
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h000000);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h800000);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h7FFFFF);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'hFFFFFF);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h000001);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h555555);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'hAAAAAA);
		send_item(rmsd_pkg::CMD_RESEED, 24'h000000);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h000000);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h000000);
		send_item(rmsd_pkg::CMD_RESEED, 24'h5A5A5A);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h800000);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h800000);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h7FFFFF);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h800001);
		send_item(rmsd_pkg::CMD_RESEED, 24'hFFFFFF);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'h2AAAAA);
		send_item(rmsd_pkg::CMD_ACCUMULATE, 24'hD55556);
		drain();

		start_phase(1'b1, -9'sd144, 9'd0, PACE_SEND_IDLE);
		run_random(160);
		drain();

		// floor above ceiling
		start_phase(1'b1, 9'd0, -9'sd144, PACE_RECV_STALL);
		run_random(160);
		drain();

		// samples ignored, limits at the ends of the register range
		start_phase(1'b0, 9'h100, 9'h0FF, PACE_BOTH);
		run_random(80);
		drain();

		start_phase(1'b1, -9'sd60, -9'sd10, PACE_PRESSURE);
		run_random(90);
		drain();

		start_phase(1'b1, 9'h100, 9'h0FF, PACE_FREE);
		run_random(160);
		drain();

		start_phase(1'b1, -9'sd100, -9'sd30, PACE_BOTH);
		run_random(90);
		drain();

		if (level_errors == 0 && levels_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/rmsd_pkg.sv
sv/rmsd_if.sv
sv/rmsd_dp.sv
sv/rmsd_ctrl.sv
sv/rms_level_dbfs_meter.sv
tb/level_checker.sv
tb/testbench.sv
